[hw/rtl/fvn_pkg.sv]
// package for the fractal value noise block: types, hash constants, register map
// used by fvn_front, fvn_back and fractal_value_noise
// no dependencies
package fvn_pkg;

    localparam int MAX_OCTAVES = 8;
    localparam int QDEPTH      = 4;
    localparam int QAW         = 2;

    localparam logic signed [30:0] HASH_MUL_X   = 31'sd374761393;
    localparam logic signed [30:0] HASH_MUL_Y   = 31'sd668265263;
    localparam logic [30:0]        HASH_MUL_MIX = 31'd1274126177;
    localparam logic [63:0]        SEED_STEP    = 64'd1000;
    localparam logic [16:0]        ONE_Q16      = 17'd65536;

    typedef enum logic [1:0] {
        REG_SEED = 2'd0,
        REG_OCT  = 2'd1,
        REG_PERS = 2'd2,
        REG_ONED = 2'd3
    } fvn_reg_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } fvn_job_t;

    typedef struct packed {
        logic [63:0] seed;
        logic [3:0]  oct_n;
        logic [15:0] pers;
        logic        use_y;
    } fvn_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SM0,
        ST_SM1,
        ST_H0,
        ST_H1,
        ST_H2,
        ST_H3,
        ST_BL,
        ST_BV,
        ST_ACC,
        ST_DIVI,
        ST_DIV,
        ST_DONE
    } fvn_state_t;

endpackage

[hw/rtl/fractal_value_noise.sv]
// Fractal value noise sampler: APB-style configuration registers, request queue
// front end and octave sequencer back end.
// Input channel: push/full with x_coord, y_coord (signed Q16.16); a request is
// taken when push is high and full is low. Up to four requests are queued.
// Result channel: empty/pop with noise_value (Q0.16); the oldest result is shown
// while empty is low and leaves when pop is high.
// Each request walks N octaves (1..8), and each octave C corners
// (4 in 2-D mode, 2 in 1-D mode); the back end serves one request at a time.
// Each request passes through the shared hash multiplier, walked once per corner,
// and the one bit per cycle divider.
// Registers (8-byte stride): 0 base_seed, 1 octave_count, 2 persistence,
// 3 one_dimensional; write only while the block is idle.
// Reset empties the queue and the result slot and loads seed 0, 4 octaves,
// persistence 0.5, 2-D mode.
// A stalled receiver holds the result; the back end then waits with the next
// finished result, and the queue keeps accepting until full.
module fractal_value_noise
    import fvn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        noise_value
);

    logic [63:0] base_seed_reg;
    logic [3:0]  octave_count_reg;
    logic [15:0] persistence_reg;
    logic        one_dimensional_reg;
    logic        wr_en;
    fvn_reg_t    reg_sel;
    logic        job_valid, job_take, res_valid;
    fvn_job_t    job;
    fvn_cfg_t    job_cfg;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = fvn_reg_t'(paddr[4:3]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_seed_reg       <= '0;
            octave_count_reg    <= 4'd4;
            persistence_reg     <= 16'd32768;
            one_dimensional_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_SEED: base_seed_reg       <= pwdata;
                REG_OCT:  octave_count_reg    <= pwdata[3:0];
                REG_PERS: persistence_reg     <= pwdata[15:0];
                REG_ONED: one_dimensional_reg <= pwdata[0];
                default:  base_seed_reg       <= base_seed_reg;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_sel)
            REG_SEED: prdata = base_seed_reg;
            REG_OCT:  prdata = 64'(octave_count_reg);
            REG_PERS: prdata = 64'(persistence_reg);
            REG_ONED: prdata = 64'(one_dimensional_reg);
            default:  prdata = '0;
        endcase
    end

    fvn_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .base_seed       (base_seed_reg),
        .octave_count    (octave_count_reg),
        .persistence     (persistence_reg),
        .one_dimensional (one_dimensional_reg),
        .job_valid       (job_valid),
        .job_take        (job_take),
        .job             (job),
        .job_cfg         (job_cfg)
    );

    fvn_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .job_cfg   (job_cfg),
        .res_valid (res_valid),
        .res_pop   (pop),
        .res_value (noise_value)
    );

    assign empty = !res_valid;

endmodule

[hw/rtl/fvn_front.sv]
// front end: request queue and per-request job setup (octave count clamp, mode)
// depends on fvn_pkg
module fvn_front
    import fvn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] x_coord,
    input  logic signed [31:0] y_coord,
    input  logic [63:0]        base_seed,
    input  logic [3:0]         octave_count,
    input  logic [15:0]        persistence,
    input  logic               one_dimensional,
    output logic               job_valid,
    input  logic               job_take,
    output fvn_job_t           job,
    output fvn_cfg_t           job_cfg
);

    fvn_job_t       mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push, do_pop;

    assign full      = (count_reg == (QAW+1)'(QDEPTH));
    assign job_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = job_take && job_valid;
    assign job       = mem[rd_ptr_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= '{x: x_coord, y: y_coord};
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // job setup: clamp octave count into 1..MAX_OCTAVES
    always_comb
    begin
        job_cfg.seed  = base_seed;
        job_cfg.pers  = persistence;
        job_cfg.use_y = !one_dimensional;
        if (octave_count == 4'd0)
        begin
            job_cfg.oct_n = 4'd1;
        end
        else if (octave_count > 4'(MAX_OCTAVES))
        begin
            job_cfg.oct_n = 4'(MAX_OCTAVES);
        end
        else
        begin
            job_cfg.oct_n = octave_count;
        end
    end

endmodule

[hw/rtl/fvn_back.sv]
// back end: octave sequencer with shared hash, smoothstep, blend and divide datapath
// depends on fvn_pkg
module fvn_back
    import fvn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_take,
    input  fvn_job_t    job,
    input  fvn_cfg_t    job_cfg,
    output logic        res_valid,
    input  logic        res_pop,
    output logic [15:0] res_value
);

    fvn_state_t  state_reg, state_next;

    logic [47:0] xs_reg, ys_reg;
    logic [63:0] seed_reg;
    logic [3:0]  oct_left_reg;
    logic [15:0] pers_reg;
    logic        use_y_reg;
    logic [31:0] tx2_reg, ty2_reg;
    logic [15:0] sx_reg, sy_reg;
    logic [1:0]  corner_reg;
    logic [15:0] cval_reg [4];
    logic [63:0] p1_reg, h_reg;
    logic [47:0] mlo_reg;
    logic [15:0] ghi_reg;
    logic [15:0] top_reg, bot_reg, v_reg;
    logic [16:0] amp_reg;
    logic [19:0] amp_sum_reg;
    logic [35:0] total_reg;
    logic [20:0] rem_reg;
    logic [15:0] dsh_reg, quo_reg;
    logic [3:0]  dcnt_reg;
    logic [15:0] res_reg;
    logic        res_valid_reg;

    logic               last_corner, res_free;
    logic [31:0]        ix, iy;
    logic [63:0]        p1_next, py, g;
    logic signed [63:0] py_prod;
    logic [47:0]        m;
    logic [49:0]        sm_x, sm_y;
    logic [20:0]        trial;

    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] s);
        logic [33:0] acc;
        acc = 34'(a) * 34'(ONE_Q16 - {1'b0, s}) + 34'(b) * 34'(s);
        return acc[31:16];
    endfunction

    assign last_corner = use_y_reg ? (corner_reg == 2'd3) : (corner_reg == 2'd1);
    assign res_free    = !res_valid_reg || res_pop;
    assign res_valid   = res_valid_reg;
    assign res_value   = res_reg;

    // lattice corner and hash arithmetic
    assign ix      = xs_reg[47:16] + {31'd0, corner_reg[0]};
    assign iy      = ys_reg[47:16] + {31'd0, corner_reg[1]};
    assign p1_next = $signed(ix) * HASH_MUL_X;
    assign py_prod = $signed(iy) * HASH_MUL_Y;
    assign py      = use_y_reg ? py_prod : 64'd0;
    assign g       = h_reg ^ (h_reg >> 13);
    assign m       = mlo_reg + {16'(ghi_reg * HASH_MUL_MIX[15:0]), 32'd0};

    // smoothstep 3t^2 - 2t^3
    assign sm_x = 50'({tx2_reg, 16'd0}) * 50'd3 - 50'(tx2_reg) * 50'(xs_reg[15:0]) * 50'd2;
    assign sm_y = 50'({ty2_reg, 16'd0}) * 50'd3 - 50'(ty2_reg) * 50'(ys_reg[15:0]) * 50'd2;

    // restoring divide step
    assign trial = {rem_reg[19:0], dsh_reg[15]};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (job_valid) state_next = ST_SM0;
            ST_SM0:  state_next = ST_SM1;
            ST_SM1:  state_next = ST_H0;
            ST_H0:   state_next = ST_H1;
            ST_H1:   state_next = ST_H2;
            ST_H2:   state_next = ST_H3;
            ST_H3:   state_next = last_corner ? ST_BL : ST_H0;
            ST_BL:   state_next = ST_BV;
            ST_BV:   state_next = ST_ACC;
            ST_ACC:  state_next = (oct_left_reg == 4'd1) ? ST_DIVI : ST_SM0;
            ST_DIVI: state_next = ST_DIV;
            ST_DIV:  if (dcnt_reg == 4'd15) state_next = ST_DONE;
            ST_DONE: if (res_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        job_take = (state_reg == ST_IDLE) && job_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_DONE && res_free)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_pop)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && res_free)
        begin
            res_reg <= quo_reg;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                xs_reg       <= 48'(job.x);
                ys_reg       <= 48'(job.y);
                seed_reg     <= job_cfg.seed;
                oct_left_reg <= job_cfg.oct_n;
                pers_reg     <= job_cfg.pers;
                use_y_reg    <= job_cfg.use_y;
                amp_reg      <= ONE_Q16;
                amp_sum_reg  <= '0;
                total_reg    <= '0;
            end
            ST_SM0:
            begin
                tx2_reg <= xs_reg[15:0] * xs_reg[15:0];
                ty2_reg <= ys_reg[15:0] * ys_reg[15:0];
            end
            ST_SM1:
            begin
                sx_reg     <= sm_x[47:32];
                sy_reg     <= sm_y[47:32];
                corner_reg <= 2'd0;
            end
            ST_H0:
            begin
                p1_reg <= p1_next;
            end
            ST_H1:
            begin
                h_reg <= p1_reg + seed_reg + py;
            end
            ST_H2:
            begin
                mlo_reg <= 48'(g[31:0]) * 48'(HASH_MUL_MIX);
                ghi_reg <= g[47:32];
            end
            ST_H3:
            begin
                cval_reg[corner_reg] <= m[31:16] ^ m[47:32];
                corner_reg           <= corner_reg + 1'b1;
            end
            ST_BL:
            begin
                top_reg <= blend(cval_reg[0], cval_reg[1], sx_reg);
                bot_reg <= blend(cval_reg[2], cval_reg[3], sx_reg);
            end
            ST_BV:
            begin
                v_reg <= use_y_reg ? blend(top_reg, bot_reg, sy_reg) : top_reg;
            end
            ST_ACC:
            begin
                total_reg    <= total_reg + 36'(v_reg) * 36'(amp_reg);
                amp_sum_reg  <= amp_sum_reg + 20'(amp_reg);
                amp_reg      <= 17'((33'(amp_reg) * 33'(pers_reg)) >> 16);
                seed_reg     <= seed_reg + SEED_STEP;
                xs_reg       <= xs_reg << 1;
                ys_reg       <= ys_reg << 1;
                oct_left_reg <= oct_left_reg - 1'b1;
            end
            ST_DIVI:
            begin
                rem_reg  <= {1'b0, total_reg[35:16]};
                dsh_reg  <= total_reg[15:0];
                quo_reg  <= '0;
                dcnt_reg <= '0;
            end
            ST_DIV:
            begin
                if (trial >= {1'b0, amp_sum_reg})
                begin
                    rem_reg <= trial - {1'b0, amp_sum_reg};
                    quo_reg <= {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[14:0], 1'b0};
                end
                dsh_reg  <= dsh_reg << 1;
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_pop |=> res_valid_reg && $stable(res_reg))
        else $error("waiting result changed");
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> amp_sum_reg != '0)
        else $error("divide by zero amplitude sum");
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < {1'b0, amp_sum_reg})
        else $error("remainder out of range");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_take |=> state_reg == ST_SM0)
        else $error("job taken outside idle");
`endif

endmodule
